// File: src/sap_pkg.sv
// shared types, widths and constants for the stereo auto-panner
// also holds the elaboration-time builder for the quarter-wave sine rom
// no dependencies
`default_nettype none

package sap_pkg;

  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 24;

  localparam int STEP_W     = 23;
  localparam int DEPTH_W    = 16;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 1'b1;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd16384;
  localparam logic [DEPTH_W-1:0] FULL_DEPTH  = 16'd32768;

  localparam int TAB_N      = 1 << SINE_TABLE_BITS;
  localparam int ROM_AW     = SINE_TABLE_BITS + 1;
  localparam int SINE_MAG_W = 16;
  localparam int SINE_W     = SINE_MAG_W + 1;

  localparam int MUL_A_W   = (SAMPLE_BITS > SINE_W) ? SAMPLE_BITS : SINE_W;
  localparam int GAIN_W    = 33;
  localparam int PROD_W    = MUL_A_W + GAIN_W;
  localparam int RND_SHIFT = 31;

  localparam logic signed [GAIN_W-1:0] GAIN_HALF  = GAIN_W'(64'h4000_0000);
  localparam logic signed [PROD_W-1:0] PROD_ROUND = PROD_W'(64'h4000_0000);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]  phase_step;
    logic [DEPTH_W-1:0] depth;
  } cfg_t;

  typedef logic [SINE_MAG_W-1:0] sine_rom_t [0:TAB_N];

  // q30 taylor series, nine terms, rounded to q15 and capped at one
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t   t;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] v;
    for (int k = 0; k <= TAB_N; k++) begin
      th   = (HALF_PI_Q30 * 64'(k)) / 64'(TAB_N);
      x2   = (th * th) >> 30;
      term = th;
      pos  = th;
      neg  = 64'd0;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      v = (pos > neg) ? (pos - neg) : 64'd0;
      v = (v + 64'd16384) >> 15;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      t[k] = SINE_MAG_W'(v);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: src/sap_sine_rom.sv
// quarter-wave sine magnitude rom with registered read
// contents built at elaboration; depends on sap_pkg
`default_nettype none

module sap_sine_rom
  import sap_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [ROM_AW-1:0]     addr,
  output logic      [SINE_MAG_W-1:0] data
);

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  always_ff @(posedge clk) begin
    data <= SINE_ROM[addr];
  end

endmodule

`default_nettype wire

// File: src/sap_core.sv
// lfo phase accumulator, sequencer and shared multiplier for one sample pair
// depends on sap_pkg and sap_sine_rom
`default_nettype none

module sap_core
  import sap_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      start,
  input  wire in_item_t  item,
  input  wire logic      res_free,
  output logic           idle,
  output logic           res_valid,
  output out_item_t      res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROM   = 3'd1;
  localparam logic [2:0] ST_PAN   = 3'd2;
  localparam logic [2:0] ST_LEFT  = 3'd3;
  localparam logic [2:0] ST_RIGHT = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                    state;
  logic [PHASE_BITS-1:0]         lfo_phase;
  logic signed [SAMPLE_BITS-1:0] left_reg;
  logic signed [SAMPLE_BITS-1:0] right_reg;
  logic signed [PROD_W-1:0]      prod;
  logic signed [GAIN_W-1:0]      pan;
  logic signed [SAMPLE_BITS-1:0] left_res;

  logic [1:0]                    quad;
  logic [SINE_TABLE_BITS-1:0]    idx;
  logic [ROM_AW-1:0]             rom_addr;
  logic [SINE_MAG_W-1:0]         rom_data;
  logic signed [MUL_A_W-1:0]     sine_val;
  logic [DEPTH_W-1:0]            depth_eff;
  logic signed [GAIN_W-1:0]      pan_now;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [GAIN_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]      mul_p;
  logic signed [PROD_W-1:0]      rnd_sum;
  logic signed [SAMPLE_BITS-1:0] rnd_res;

  assign quad     = lfo_phase[PHASE_BITS-1 -: 2];
  assign idx      = lfo_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? (ROM_AW'(TAB_N) - {1'b0, idx}) : {1'b0, idx};

  sap_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign depth_eff = (cfg.depth > FULL_DEPTH) ? FULL_DEPTH : cfg.depth;
  assign pan_now   = prod[GAIN_W-1:0];

  always_comb begin
    sine_val = signed'(MUL_A_W'(rom_data));
    if (quad[1]) begin
      sine_val = -sine_val;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_PAN: begin
        mul_a = sine_val;
        mul_b = signed'(GAIN_W'(depth_eff));
      end
      ST_LEFT: begin
        mul_a = MUL_A_W'(left_reg);
        mul_b = GAIN_HALF - pan_now;
      end
      ST_RIGHT: begin
        mul_a = MUL_A_W'(right_reg);
        mul_b = GAIN_HALF + pan;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign rnd_sum = prod + PROD_ROUND;
  assign rnd_res = rnd_sum[RND_SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lfo_phase <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            lfo_phase <= lfo_phase + PHASE_BITS'(cfg.phase_step);
            state     <= ST_ROM;
          end
        end
        ST_ROM:   state <= ST_PAN;
        ST_PAN:   state <= ST_LEFT;
        ST_LEFT:  state <= ST_RIGHT;
        ST_RIGHT: state <= ST_DONE;
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      left_reg  <= item.left_sample;
      right_reg <= item.right_sample;
    end
    if (state == ST_PAN || state == ST_LEFT || state == ST_RIGHT) begin
      prod <= mul_p;
    end
    if (state == ST_LEFT) begin
      pan <= pan_now;
    end
    if (state == ST_RIGHT) begin
      left_res <= rnd_res;
    end
  end

  assign idle          = (state == ST_IDLE);
  assign res_valid     = (state == ST_DONE) && res_free;
  assign res.left_out  = left_res;
  assign res.right_out = rnd_res;

endmodule

`default_nettype wire

// File: src/stereo_auto_pan_lfo.sv
// Sine LFO auto-panner, top level.
// Input channel in_valid/in_ready carries one stereo pair per item
// (in_item.left_sample, in_item.right_sample, signed). Output channel
// out_valid/out_ready carries one panned pair per input item.
// Each item advances the LFO phase by phase_step, reads a quarter-wave sine
// rom, forms pan = depth * sine and scales left by (1-pan)/2 and right by
// (1+pan)/2, rounded to nearest with halves going up.
// Sequence: a result is loaded into the output register once its item has
// passed the states rom, pan, left, right and done; a new item is taken only
// when the core is idle again. The single shared multiplier is used three
// times per item, after one registered rom read.
// Configuration: cfg_we/cfg_index/cfg_data write phase_step (index 0) or
// depth (index 1) at once; write only while the block is idle.
// Reset (rst, synchronous) clears the LFO phase, sets phase_step to 0 and
// depth to half scale, and empties the output register.
// A stalled receiver holds the result in the output register; the next item
// is still taken and worked on, and waits at its end until the register frees.
// depends on sap_pkg and sap_core
`default_nettype none

module stereo_auto_pan_lfo
  import sap_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      core_idle;
  logic      res_valid;
  logic      res_free;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step <= '0;
      cfg.depth      <= DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP: cfg.phase_step <= cfg_data[STEP_W-1:0];
        REG_DEPTH:      cfg.depth      <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = core_idle;
  assign res_free = !out_valid || out_ready;

  sap_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (in_valid),
    .item      (in_item),
    .res_free  (res_free),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire
